@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ design/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and the month table of the date difference block.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned NUM_STAGES = 4;

  typedef logic        [13:0] year_t;
  typedef logic        [3:0]  month_t;
  typedef logic        [4:0]  day_t;
  typedef logic        [8:0]  dbm_t;     // days before month, up to 365
  typedef logic        [22:0] dnum_t;    // day number since year 0
  typedef logic signed [22:0] count_t;

  // Pipeline control shared between the stage controller and the datapath.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;   // stage register takes new contents
    logic [NUM_STAGES-1:0] valid;  // stage holds a live transaction
  } gdd_ctrl_t;

  localparam month_t MONTH_LAST = 4'd12;

  // Reciprocal of 100: floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT
  // for every x below 43690, which covers year + 99 for 14-bit years.
  localparam int unsigned RECIP_SHIFT = 21;
  localparam logic [14:0] RECIP_100   = 15'd20972;

  localparam dbm_t DAYS_BEFORE [13] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Month to table row: month zero has no months before it, months
  // above twelve take the whole year.
  function automatic logic [3:0] month_row(month_t m);
    logic [3:0] row;
    if (m == 4'd0) begin
      row = 4'd0;
    end else if (m > MONTH_LAST) begin
      row = MONTH_LAST;
    end else begin
      row = m - 4'd1;
    end
    return row;
  endfunction

endpackage

@@ design/gdd_if.sv @@
// ----------------------------------------------------------------------------
// gdd_if
// Valid/ready channels for date pairs in and day counts out.
// ----------------------------------------------------------------------------
interface gdd_in_if;
  import gdd_pkg::*;

  logic   valid;
  logic   ready;
  year_t  start_year;
  month_t start_month;
  day_t   start_day;
  year_t  end_year;
  month_t end_month;
  day_t   end_day;
  logic   include_end;

  modport source (
    output valid, start_year, start_month, start_day,
           end_year, end_month, end_day, include_end,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day,
           end_year, end_month, end_day, include_end,
    output ready
  );
endinterface

interface gdd_out_if;
  import gdd_pkg::*;

  logic   valid;
  logic   ready;
  count_t day_count;

  modport source (output valid, day_count, input ready);
  modport sink   (input valid, day_count, output ready);
endinterface

@@ design/gdd_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdd_pipe_ctrl
// Stage valid bits and load enables; a bubble in any stage is filled.
// ----------------------------------------------------------------------------
module gdd_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output gdd_pkg::gdd_ctrl_t ctrl_o
);
  import gdd_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

@@ design/gdd_day_number.sv @@
// ----------------------------------------------------------------------------
// gdd_day_number
// Three-stage day number: days of all years before the year plus day of year.
// ----------------------------------------------------------------------------
module gdd_day_number (
  input  logic               clk_i,
  input  gdd_pkg::gdd_ctrl_t ctrl_i,
  input  gdd_pkg::year_t     year_i,
  input  gdd_pkg::month_t    month_i,
  input  gdd_pkg::day_t      day_i,
  output gdd_pkg::dnum_t     num_o
);
  import gdd_pkg::*;

  // Stage 1: ceil(year/100) product, month table.
  logic [14:0] yp99;
  logic [29:0] prod_d;
  logic [3:0]  row;

  year_t       s1_year_q;
  logic [29:0] s1_prod_q;
  dbm_t        s1_dbm_q;
  logic        s1_late_q;   // month after February
  day_t        s1_day_q;

  assign yp99   = {1'b0, year_i} + 15'd99;
  assign prod_d = yp99 * RECIP_100;
  assign row    = month_row(month_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      s1_year_q <= year_i;
      s1_prod_q <= prod_d;
      s1_dbm_q  <= DAYS_BEFORE[row];
      s1_late_q <= (row >= 4'd2);
      s1_day_q  <= day_i;
    end
  end

  // Stage 2: year part of the day number and the leap test.
  // q100 = ceil(y/100); ceil(y/400) = (q100 + 3) >> 2.
  logic [7:0]  q100;
  logic [14:0] q100_x100;
  logic        div100;
  logic        leap;
  dnum_t       base_d;

  assign q100      = s1_prod_q[RECIP_SHIFT +: 8];
  assign q100_x100 = {7'd0, q100} * 15'd100;
  assign div100    = (q100_x100 == {1'b0, s1_year_q});
  // Divisible by 100: then q100 is y/100 and must itself be divisible by 4.
  assign leap      = (s1_year_q[1:0] == 2'd0) && (!div100 || (q100[1:0] == 2'd0));

  always_comb begin
    base_d = 23'(s1_year_q) * 23'd365
           + 23'(({1'b0, s1_year_q} + 15'd3) >> 2)
           - 23'(q100)
           + 23'(({1'b0, q100} + 9'd3) >> 2);
  end

  dnum_t s2_base_q;
  dbm_t  s2_dbm_q;
  logic  s2_leap_q;
  day_t  s2_day_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      s2_base_q <= base_d;
      s2_dbm_q  <= s1_dbm_q;
      s2_leap_q <= s1_late_q && leap;
      s2_day_q  <= s1_day_q;
    end
  end

  // Stage 3: add the day of the year.
  dnum_t s3_num_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      s3_num_q <= s2_base_q + 23'(s2_dbm_q) + 23'(s2_leap_q) + 23'(s2_day_q);
    end
  end

  assign num_o = s3_num_q;

endmodule

@@ design/gregorian_date_difference.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_difference - signed days between two Gregorian dates
// Accepted transactions pass through a four-stage pipeline to the result; throughput one
// transaction per cycle while the output is not stalled; an output stall holds
// only full stages, bubbles close up. Reset empties the pipeline, nothing else.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gregorian_date_difference (
  input  logic  clk_i,
  input  logic  rst_ni,
  gdd_in_if.sink    req_i,
  gdd_out_if.source rsp_o
);
  import gdd_pkg::*;

  // Stage plan, per date:
  //   1: (year + 99) times the reciprocal of 100, month table lookup
  //   2: year * 365 + leap days before the year, leap test
  //   3: plus days before month, leap day, day of month
  //   4: end number minus start number plus include_end (here)
  gdd_ctrl_t ctrl;

  gdd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // Any stage with room lets the chain move, so the input is ready even
  // while a finished count waits at the output.
  assign req_i.ready = ctrl.load[0];

  dnum_t start_num;
  dnum_t end_num;

  gdd_day_number u_start (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .year_i  (req_i.start_year),
    .month_i (req_i.start_month),
    .day_i   (req_i.start_day),
    .num_o   (start_num)
  );

  gdd_day_number u_end (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .year_i  (req_i.end_year),
    .month_i (req_i.end_month),
    .day_i   (req_i.end_day),
    .num_o   (end_num)
  );

  // include_end rides along with the day number stages.
  logic [2:0] inc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      inc_q[0] <= req_i.include_end;
    end
    if (ctrl.load[1]) begin
      inc_q[1] <= inc_q[0];
    end
    if (ctrl.load[2]) begin
      inc_q[2] <= inc_q[1];
    end
  end

  // Final stage: exact difference in 24 bits, low 23 kept (two's complement).
  logic [23:0] diff;
  count_t      count_q;

  assign diff = {1'b0, end_num} - {1'b0, start_num} + 24'(inc_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      count_q <= count_t'(diff[22:0]);
    end
  end

  assign rsp_o.valid     = ctrl.valid[NUM_STAGES-1];
  assign rsp_o.day_count = count_q;

  // An accepted transaction always lands in the first stage.
  `ASSERT_NXT(a_accept_fills_s1, clk_i, rst_ni, req_i.valid && req_i.ready, ctrl.valid[0])

  // With every stage full and the output stalled, nothing more may enter.
  `ASSERT_IMP(a_full_blocks_input, clk_i, rst_ni, (&ctrl.valid) && !rsp_o.ready, !req_i.ready)

  // A live stage that cannot move keeps its transaction.
  `ASSERT_NXT(a_s3_holds, clk_i, rst_ni, ctrl.valid[2] && !ctrl.load[2], ctrl.valid[2])

endmodule
